FILE: design/integer_to_ascii_formatter_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer to ASCII formatter unit
// Immediate-consequence and next-cycle property wrappers, clocked on clk
// and disabled while rst_n is low. Empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent checked in the same cycle as the antecedent.
`define ITA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ita: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define ITA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ita: next-cycle check failed");

`else

`define ITA_ASSERT_NOW(label, ante, cons)
`define ITA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: design/ita_pkg.sv
// ----------------------------------------------------------------------------
// ita_pkg
// Shared widths, format codes, character table and the job record passed
// from the converter to the character emitter.
// ----------------------------------------------------------------------------
package ita_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int IN_VALUE_W     = 64;
  localparam int OP_W           = 2;
  localparam int COUNT_W        = 5;
  localparam int CHAR_W         = 7;
  localparam int MAX_HEX_DIGITS = 16;
  localparam int DEC_DIGITS     = 20;
  localparam int DIGITS_W       = 4 * DEC_DIGITS;
  localparam int REM_W          = $clog2(DEC_DIGITS + 1);

  // format codes
  localparam logic [OP_W-1:0] OP_SDEC = 2'd0;
  localparam logic [OP_W-1:0] OP_UDEC = 2'd1;
  localparam logic [OP_W-1:0] OP_HEX  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

  localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
  };

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    return DIGIT_CHARS[d];
  endfunction

  // One converted value: 20 nibbles, MS nibble on top.
  typedef struct packed {
    logic [DIGITS_W-1:0] digits;
    logic                neg;
    logic                fixed;   // hex with a nonzero digit count
    logic [COUNT_W-1:0]  count;   // saturated hex digit count
  } ita_job_t;

endpackage

FILE: design/ita_if.sv
// ----------------------------------------------------------------------------
// ita_if
// Valid/ready channel interfaces for the formatter input and character
// output.
// ----------------------------------------------------------------------------
interface ita_in_if;
  logic                             valid;
  logic                             ready;
  logic [ita_pkg::OP_W-1:0]         op;
  logic [ita_pkg::IN_VALUE_W-1:0]   value;
  logic [ita_pkg::COUNT_W-1:0]      digit_count;

  modport source (output valid, output op, output value, output digit_count, input ready);
  modport sink   (input valid, input op, input value, input digit_count, output ready);
endinterface

interface ita_out_if;
  logic                         valid;
  logic                         ready;
  logic [ita_pkg::CHAR_W-1:0]   ascii_char;
  logic                         last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

FILE: design/ita_conv.sv
// ----------------------------------------------------------------------------
// ita_conv
// Accepts a transaction, takes the magnitude and runs a bit-serial
// shift-and-add-3 binary to BCD conversion, one value bit per cycle.
// Hex values are loaded as nibbles directly.
// ----------------------------------------------------------------------------
module ita_conv #(
  parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  ita_in_if.sink           in_ch,
  output ita_pkg::ita_job_t job,
  output logic             job_valid,
  input  logic             job_ready
);
  import ita_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_HOLD} state_t;

  state_t                state_r;
  logic [VALUE_BITS-1:0] bin_r;
  logic [CNT_W-1:0]      cnt_r;
  ita_job_t              job_r;

  logic [VALUE_BITS-1:0] v_low;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic [COUNT_W-1:0]    count_sat;
  logic [DIGITS_W-1:0]   dd_adj;
  logic [DIGITS_W-1:0]   dd_nxt;

  function automatic logic [DIGITS_W-1:0] bcd_adjust(input logic [DIGITS_W-1:0] d);
    logic [DIGITS_W-1:0] r;
    logic [3:0]          nib;
    r = d;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      nib = d[4*i +: 4];
      if (nib >= 4'd5) begin
        r[4*i +: 4] = nib + 4'd3;
      end
    end
    return r;
  endfunction

  assign v_low     = in_ch.value[VALUE_BITS-1:0];
  assign neg       = (in_ch.op == OP_SDEC) && v_low[VALUE_BITS-1];
  assign mag       = neg ? (~v_low + VALUE_BITS'(1)) : v_low;
  assign count_sat = (in_ch.digit_count > COUNT_W'(MAX_HEX_DIGITS)) ?
                     COUNT_W'(MAX_HEX_DIGITS) : in_ch.digit_count;
  assign dd_adj    = bcd_adjust(job_r.digits);
  assign dd_nxt    = {dd_adj[DIGITS_W-2:0], bin_r[VALUE_BITS-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            job_r.neg   <= neg;
            job_r.fixed <= (in_ch.op == OP_HEX) && (count_sat != '0);
            job_r.count <= count_sat;
            bin_r       <= mag;
            cnt_r       <= CNT_W'(VALUE_BITS - 1);
            case (in_ch.op) inside
              OP_SDEC, OP_UDEC: begin
                job_r.digits <= '0;
                state_r      <= S_CONV;
              end
              OP_HEX: begin
                job_r.digits <= DIGITS_W'(v_low);
                state_r      <= S_HOLD;
              end
              default: ;  // unused format: dropped
            endcase
          end
        end
        S_CONV: begin
          job_r.digits <= dd_nxt;
          bin_r        <= {bin_r[VALUE_BITS-2:0], 1'b0};
          cnt_r        <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (job_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign job_valid   = (state_r == S_HOLD);
  assign job         = job_r;

endmodule

FILE: design/ita_emit.sv
// ----------------------------------------------------------------------------
// ita_emit
// Drops leading digits one nibble per cycle, then sends the sign and the
// digits out one character per transaction through an output register.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_unit_macros.svh"

module ita_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  ita_pkg::ita_job_t job,
  input  logic              job_valid,
  output logic              job_ready,
  ita_out_if.source         out_ch
);
  import ita_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SKIP, S_EMIT} state_t;

  state_t              state_r;
  logic [DIGITS_W-1:0] dig_r;
  logic [REM_W-1:0]    rem_r;
  logic                neg_r;
  logic                fixed_r;
  logic [COUNT_W-1:0]  cnt_r;
  logic                out_valid_r;
  logic [CHAR_W-1:0]   out_char_r;
  logic                out_last_r;

  logic [3:0] top;
  logic       skip_w;
  logic       out_free;
  logic       load_w;

  assign top      = dig_r[DIGITS_W-1 -: 4];
  // fixed hex: keep exactly cnt_r nibbles; otherwise drop leading zeros
  assign skip_w   = fixed_r ? (rem_r > REM_W'(cnt_r))
                            : ((top == 4'd0) && (rem_r > REM_W'(1)));
  assign out_free = !out_valid_r || out_ch.ready;
  // a new character goes into the output register this cycle
  assign load_w   = (state_r == S_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load_w) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            dig_r   <= job.digits;
            neg_r   <= job.neg;
            fixed_r <= job.fixed;
            cnt_r   <= job.count;
            rem_r   <= REM_W'(DEC_DIGITS);
            state_r <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (skip_w) begin
            dig_r <= {dig_r[DIGITS_W-5:0], 4'd0};
            rem_r <= rem_r - 1'b1;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (neg_r) begin
              out_char_r <= CHAR_MINUS;
              out_last_r <= 1'b0;
              neg_r      <= 1'b0;
            end else begin
              out_char_r <= digit_char(top);
              out_last_r <= (rem_r == REM_W'(1));
              dig_r      <= {dig_r[DIGITS_W-5:0], 4'd0};
              rem_r      <= rem_r - 1'b1;
              if (rem_r == REM_W'(1)) begin
                state_r <= S_IDLE;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign job_ready         = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.ascii_char = out_char_r;
  assign out_ch.last       = out_last_r;

  `ITA_ASSERT_NOW(a_emit_rem_nonzero, state_r == S_EMIT, rem_r != '0)
  `ITA_ASSERT_NEXT(a_load_to_skip, job_valid && job_ready, (state_r == S_SKIP) && (rem_r == REM_W'(DEC_DIGITS)))
  `ITA_ASSERT_NOW(a_minus_not_last, out_valid_r && (out_char_r == CHAR_MINUS), !out_last_r)
  `ITA_ASSERT_NOW(a_fixed_skip_end, (state_r == S_SKIP) && !skip_w && fixed_r, rem_r == REM_W'(cnt_r))

endmodule

FILE: design/integer_to_ascii_formatter_unit.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Prints a binary value as ASCII signed decimal, unsigned decimal or hex.
// ----------------------------------------------------------------------------
// Each input transaction carries a value, a format (signed decimal, unsigned
// decimal, lower-case hex) and a hex digit count; the unit answers with one
// output transaction per character, most significant first, with last set on
// the final one. Negative signed values get a leading '-' and are printed
// from their unsigned magnitude, so the most negative value comes out right.
// Zero prints as "0". Hex with count 0 prints the minimal digits, a nonzero
// count prints that many low nibbles (saturated at 16). The unused format
// code is accepted and produces nothing. Only the low VALUE_BITS bits of the
// value are used. A decimal value runs through the bit-serial BCD converter
// (one bit per cycle) and is then handed off; the emitter drops the leading
// digits (20 minus the number of digits printed) and sends one character
// per output transaction. Hex skips the converter and goes straight to the
// handoff. The converter takes the next value while the emitter is still
// sending characters, and any output stall holds the emitter.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit #(
  parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ita_in_if.sink    in_ch,
  ita_out_if.source out_ch
);
  import ita_pkg::*;

  // converter -> emitter handoff
  ita_job_t job;
  logic     job_valid;
  logic     job_ready;

  // bit-serial magnitude to BCD, or direct hex nibble load
  ita_conv #(
    .VALUE_BITS (VALUE_BITS)
  ) u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready)
  );

  // leading digit drop and character output register
  ita_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .out_ch    (out_ch)
  );

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: integer to ASCII formatter unit testbench
// Sends values in signed decimal, unsigned decimal and hex format, and also
// the unused format code, through the input channel. Each accepted value is
// turned into its expected character string, and the string is checked
// character by character against the output channel, including the last
// flag. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ita_pkg::*;

  localparam int VALUE_BITS = VALUE_BITS_DEF;
  // Low VALUE_BITS bits of a value; the unit ignores everything above them.
  localparam logic [IN_VALUE_W-1:0] VALUE_MASK = {IN_VALUE_W{1'b1}} >> (64 - VALUE_BITS);
  // Format code with no meaning: the unit takes it and prints nothing.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;
  localparam int RANDOM_VALUES = 76;
  localparam int DRAIN_CYCLES  = 200;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } out_char_t;

  // --------------------------------------------------------------------------
  // Expected character strings, oldest first
  // --------------------------------------------------------------------------
  class char_scoreboard_t;
    out_char_t pending_chars[$];
    int        errors;

    function automatic logic [CHAR_W-1:0] nibble_char(input logic [3:0] d);
      if (d < 4'd10) return ASCII_ZERO + CHAR_W'(d);
      return ASCII_LOWER_A + CHAR_W'(d - 4'd10);
    endfunction

    function void push_char(input logic [CHAR_W-1:0] ch);
      out_char_t c;
      c.ch   = ch;
      c.last = 1'b0;
      pending_chars.push_back(c);
    endfunction

    // Decimal digits of mag, most significant first. Zero gives one '0'.
    function void push_decimal(input logic [IN_VALUE_W-1:0] mag);
      logic [3:0] rev [DEC_DIGITS];
      int         n;
      n = 0;
      if (mag == '0) begin
        push_char(ASCII_ZERO);
        return;
      end
      while (mag != '0) begin
        rev[n] = 4'(mag % 10);
        mag    = mag / 10;
        n++;
      end
      for (int i = n - 1; i >= 0; i--) push_char(nibble_char(rev[i]));
    endfunction

    // Called for every accepted input transaction.
    function void add_value(input logic [OP_W-1:0] op, input logic [IN_VALUE_W-1:0] value,
                            input logic [COUNT_W-1:0] digit_count);
      logic [IN_VALUE_W-1:0] v;
      int                    start;
      int                    n;
      v     = value & VALUE_MASK;
      start = pending_chars.size();
      case (op)
        OP_SDEC: begin
          if (v[VALUE_BITS-1]) begin
            push_char(CHAR_MINUS);
            // magnitude as unsigned, so the most negative value is fine
            v = (~v + 1'b1) & VALUE_MASK;
          end
          push_decimal(v);
        end
        OP_UDEC: push_decimal(v);
        OP_HEX: begin
          if (digit_count == '0) begin
            n = 1;
            while (n < MAX_HEX_DIGITS && (v >> (4 * n)) != '0) n++;
          end else if (digit_count > MAX_HEX_DIGITS) begin
            n = MAX_HEX_DIGITS;
          end else begin
            n = int'(digit_count);
          end
          for (int i = n - 1; i >= 0; i--) push_char(nibble_char(4'(v >> (4 * i))));
        end
        default: ;
      endcase
      if (pending_chars.size() > start) pending_chars[pending_chars.size() - 1].last = 1'b1;
    endfunction

    // Called for every accepted output transaction.
    function void check_char(input logic [CHAR_W-1:0] ch, input logic last);
      out_char_t exp_c;
      if (pending_chars.size() == 0) begin
        $error("unexpected character: ascii_char %h, last %b", ch, last);
        errors++;
        return;
      end
      exp_c = pending_chars.pop_front();
      if (ch !== exp_c.ch) begin
        $error("ascii_char mismatch: expected %h, actual %h", exp_c.ch, ch);
        errors++;
      end
      if (last !== exp_c.last) begin
        $error("last mismatch: expected %b, actual %b", exp_c.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic quiet;   // no idling on either side while set

  ita_in_if  in_ch ();
  ita_out_if out_ch ();

  char_scoreboard_t sb;

  integer_to_ascii_formatter_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Output side: ready toggles at the falling edge, characters are checked
  // at the rising edge.
  // --------------------------------------------------------------------------
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_char(out_ch.ascii_char, out_ch.last);
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Starts and ends at a falling edge. Valid stays high across back-to-back
  // transactions; it only drops when a gap is taken.
  task automatic send_value(input logic [OP_W-1:0] op, input logic [IN_VALUE_W-1:0] value,
                            input logic [COUNT_W-1:0] digit_count);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.value       <= value;
    in_ch.digit_count <= digit_count;
    do @(posedge clk); while (!in_ch.ready);
    sb.add_value(op, value, digit_count);
    @(negedge clk);
  endtask

  // Values that hit digit boundaries, sign edges and narrow widths.
  function automatic logic [IN_VALUE_W-1:0] random_value();
    logic [IN_VALUE_W-1:0] p;
    int                    k;
    case ($urandom_range(0, 7))
      0: return {$urandom, $urandom};
      1: return IN_VALUE_W'($urandom_range(0, 1000));
      2: return {$urandom, $urandom} >> $urandom_range(0, 63);
      3: begin
        // power of ten, one below, or one above
        k = $urandom_range(0, 19);
        p = 1;
        repeat (k) p = p * 10;
        return p + IN_VALUE_W'($urandom_range(0, 2)) - 1'b1;
      end
      4: return -IN_VALUE_W'($urandom_range(1, 1000));
      5: return $urandom_range(0, 1) ? (64'h8000_0000_0000_0000 | IN_VALUE_W'($urandom_range(0, 15)))
                                     : (64'h7fff_ffff_ffff_ffff ^ IN_VALUE_W'($urandom_range(0, 15)));
      6: return {IN_VALUE_W{1'b1}} - IN_VALUE_W'($urandom_range(0, 15));
      default: return IN_VALUE_W'($urandom_range(0, 1));
    endcase
  endfunction

  initial begin
    logic [OP_W-1:0]       op;
    logic [COUNT_W-1:0]    digit_count;
    int                    sent;
    int                    r;

    sb    = new();
    quiet = 1'b0;
    rst_n = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_SDEC;
    in_ch.value       = '0;
    in_ch.digit_count = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: sign edges, zero, widest decimal, hex padding/truncation,
    // saturated count, ignored count for decimal, unused format.
    send_value(OP_SDEC, 64'd0, 5'd0);
    send_value(OP_SDEC, 64'd1, 5'd0);
    send_value(OP_SDEC, {IN_VALUE_W{1'b1}}, 5'd0);
    send_value(OP_SDEC, 64'h8000_0000_0000_0000, 5'd0);
    send_value(OP_SDEC, 64'h7fff_ffff_ffff_ffff, 5'd31);
    send_value(OP_SDEC, -64'd10, 5'd7);
    send_value(OP_UDEC, 64'd0, 5'd0);
    send_value(OP_UDEC, {IN_VALUE_W{1'b1}}, 5'd0);
    send_value(OP_UDEC, 64'd9, 5'd16);
    send_value(OP_UDEC, 64'd10, 5'd0);
    send_value(OP_UDEC, 64'd10_000_000_000_000_000_000, 5'd0);
    send_value(OP_UDEC, 64'h8000_0000_0000_0000, 5'd3);
    send_value(OP_HEX, 64'd0, 5'd0);
    send_value(OP_HEX, 64'hdead_beef, 5'd0);
    send_value(OP_HEX, {IN_VALUE_W{1'b1}}, 5'd0);
    send_value(OP_HEX, 64'h123, 5'd16);
    send_value(OP_HEX, 64'h1234_5678_9abc_def0, 5'd4);
    send_value(OP_HEX, 64'hfedc_ba98_7654_3210, 5'd31);
    send_value(OP_HEX, 64'h8000_0000_0000_0001, 5'd17);
    send_value(OP_HEX, 64'habc, 5'd1);
    send_value(OP_HEX, 64'd0, 5'd16);
    send_value(OP_UNUSED, {IN_VALUE_W{1'b1}}, 5'd31);
    send_value(OP_UNUSED, 64'd0, 5'd0);
    send_value(OP_SDEC, 64'hffff_ffff_8000_0000, 5'd0);

    // Random: unused format codes mixed in but not counted.
    sent = 0;
    while (sent < RANDOM_VALUES) begin
      quiet = (sent >= 40 && sent < 60);
      r = $urandom_range(0, 19);
      if (r == 0) op = OP_UNUSED;
      else if (r < 7) op = OP_SDEC;
      else if (r < 13) op = OP_UDEC;
      else op = OP_HEX;
      if ($urandom_range(0, 9) == 0) digit_count = COUNT_W'($urandom_range(17, 31));
      else digit_count = COUNT_W'($urandom_range(0, 16));
      send_value(op, random_value(), digit_count);
      if (op != OP_UNUSED) sent++;
    end
    quiet = 1'b0;
    in_ch.valid <= 1'b0;

    // Drain, then give the unit time to show any stray character.
    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending_chars.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #1_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
